// ===== design/nlnorm_pkg.sv =====
// shared types and constants of the newline normalizer
`timescale 1ns / 1ps
`default_nettype none
package nlnorm_pkg;

  // counter width of the terminator statistics
  localparam int COUNT_WIDTH = 32;
  localparam int CHAR_WIDTH  = 16;
  localparam int QUEUE_DEPTH = 2;

  // character codes
  localparam logic [CHAR_WIDTH-1:0] CH_CR = 16'h000D;
  localparam logic [CHAR_WIDTH-1:0] CH_LF = 16'h000A;

  // newline style codes, also used for the detected style
  localparam logic [1:0] STYLE_LF   = 2'd0;
  localparam logic [1:0] STYLE_CR   = 2'd1;
  localparam logic [1:0] STYLE_CRLF = 2'd2;

  // terminator emitted last and not yet counted
  typedef enum logic [3:0] {
    PEND_NONE = 4'b0001,
    PEND_CR   = 4'b0010,
    PEND_LF   = 4'b0100,
    PEND_CRLF = 4'b1000
  } pend_t;

  // one classified item for the emit side
  typedef struct packed {
    logic [CHAR_WIDTH-1:0] ch;        // first character to emit
    logic                  valid;     // 0 for the empty end marker
    logic                  dual;      // emit CR then LF
    logic                  last;      // last item of the text
    logic [1:0]            detected;  // majority style, 0 unless last
  } cmd_t;

endpackage
`default_nettype wire

// ===== design/nlnorm_front.sv =====
// front end: accepts characters, tracks terminators and counts, classifies items
`timescale 1ns / 1ps
`default_nettype none
module nlnorm_front (
  input  wire                                logic clk,
  input  wire                                logic rst,
  input  wire                                logic cfg_we,
  input  wire                                logic [1:0] cfg_wdata,
  input  wire                                logic in_valid,
  input  wire                                logic [nlnorm_pkg::CHAR_WIDTH-1:0] in_char,
  input  wire                                logic in_last,
  input  wire                                logic queue_full,
  output logic                               in_ready,
  output logic                               push,
  output nlnorm_pkg::cmd_t                   push_cmd
);

  localparam int CW = nlnorm_pkg::COUNT_WIDTH;

  logic [1:0]              style;
  nlnorm_pkg::pend_t       pend, pend_next;
  logic [CW-1:0]           cr_cnt, lf_cnt, crlf_cnt;
  logic [CW-1:0]           cr_next, lf_next, crlf_next;
  logic                    fresh, bump_cr, bump_lf, bump_crlf;
  logic                    is_cr, is_lf, accept;
  logic [1:0]              majority;

  assign in_ready = !queue_full;
  assign accept   = in_valid && in_ready;
  assign is_cr    = (in_char == nlnorm_pkg::CH_CR);
  assign is_lf    = (in_char == nlnorm_pkg::CH_LF);

  // resolve the pending terminator against the new character
  always_comb begin
    fresh     = 1'b1;
    bump_cr   = 1'b0;
    bump_lf   = 1'b0;
    bump_crlf = 1'b0;
    pend_next = nlnorm_pkg::PEND_NONE;
    unique case (pend)
      nlnorm_pkg::PEND_CR: begin
        if (is_lf) begin
          pend_next = nlnorm_pkg::PEND_CRLF;
          fresh     = 1'b0;
        end else begin
          bump_cr = 1'b1;
        end
      end
      nlnorm_pkg::PEND_LF: begin
        if (is_cr) fresh = 1'b0;
        else       bump_lf = 1'b1;
      end
      nlnorm_pkg::PEND_CRLF: begin
        bump_crlf = 1'b1;
      end
      default: ;
    endcase
    if (fresh && is_cr) pend_next = nlnorm_pkg::PEND_CR;
    if (fresh && is_lf) pend_next = nlnorm_pkg::PEND_LF;
  end

  // saturating counter updates
  assign cr_next   = (bump_cr && cr_cnt != {CW{1'b1}}) ? cr_cnt + CW'(1) : cr_cnt;
  assign lf_next   = (bump_lf && lf_cnt != {CW{1'b1}}) ? lf_cnt + CW'(1) : lf_cnt;
  assign crlf_next = (bump_crlf && crlf_cnt != {CW{1'b1}}) ? crlf_cnt + CW'(1) : crlf_cnt;

  // majority style over the updated counts
  always_comb begin
    priority if (lf_next > crlf_next && lf_next >= cr_next) majority = nlnorm_pkg::STYLE_LF;
    else if (cr_next > lf_next && cr_next > crlf_next)       majority = nlnorm_pkg::STYLE_CR;
    else                                                      majority = nlnorm_pkg::STYLE_CRLF;
  end

  // build the item for the emit side
  always_comb begin
    push_cmd.valid    = 1'b1;
    push_cmd.dual     = 1'b0;
    push_cmd.last     = in_last;
    push_cmd.detected = in_last ? majority : nlnorm_pkg::STYLE_LF;
    push_cmd.ch       = in_char;
    if (fresh && (is_cr || is_lf)) begin
      unique case (style)
        nlnorm_pkg::STYLE_LF: push_cmd.ch = nlnorm_pkg::CH_LF;
        nlnorm_pkg::STYLE_CR: push_cmd.ch = nlnorm_pkg::CH_CR;
        default: begin
          push_cmd.ch   = nlnorm_pkg::CH_CR;
          push_cmd.dual = 1'b1;
        end
      endcase
    end else if (!fresh) begin
      push_cmd.ch    = '0;
      push_cmd.valid = 1'b0;
    end
  end

  assign push = accept && (fresh || in_last);

  // style register
  always_ff @(posedge clk) begin
    if (rst)         style <= nlnorm_pkg::STYLE_CRLF;
    else if (cfg_we) style <= cfg_wdata;
  end

  // terminator state and counters, cleared at the end of a text
  always_ff @(posedge clk) begin
    if (rst) begin
      pend     <= nlnorm_pkg::PEND_NONE;
      cr_cnt   <= '0;
      lf_cnt   <= '0;
      crlf_cnt <= '0;
    end else if (accept) begin
      if (in_last) begin
        pend     <= nlnorm_pkg::PEND_NONE;
        cr_cnt   <= '0;
        lf_cnt   <= '0;
        crlf_cnt <= '0;
      end else begin
        pend     <= pend_next;
        cr_cnt   <= cr_next;
        lf_cnt   <= lf_next;
        crlf_cnt <= crlf_next;
      end
    end
  end

endmodule
`default_nettype wire

// ===== design/nlnorm_queue.sv =====
// short item queue between the front end and the emit side
`timescale 1ns / 1ps
`default_nettype none
module nlnorm_queue (
  input  wire              logic clk,
  input  wire              logic rst,
  input  wire              logic push,
  input  nlnorm_pkg::cmd_t push_cmd,
  input  wire              logic pop,
  output logic             full,
  output logic             empty,
  output nlnorm_pkg::cmd_t head
);

  localparam int AW = $clog2(nlnorm_pkg::QUEUE_DEPTH);

  nlnorm_pkg::cmd_t entries [nlnorm_pkg::QUEUE_DEPTH];
  logic [AW-1:0]    wr_ptr, rd_ptr;
  logic [AW:0]      count;

  assign full  = (count == (AW+1)'(nlnorm_pkg::QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = entries[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_cmd;
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + AW'(1);
      if (pop)  rd_ptr <= rd_ptr + AW'(1);
      if (push && !pop)      count <= count + (AW+1)'(1);
      else if (pop && !push) count <= count - (AW+1)'(1);
    end
  end

endmodule
`default_nettype wire

// ===== design/nlnorm_back.sv =====
// emit side: turns queued items into one or two output transfers
`timescale 1ns / 1ps
`default_nettype none
module nlnorm_back (
  input  wire              logic clk,
  input  wire              logic rst,
  input  wire              logic empty,
  input  nlnorm_pkg::cmd_t head,
  output logic             pop,
  output logic             out_valid,
  input  wire              logic out_ready,
  output logic [nlnorm_pkg::CHAR_WIDTH-1:0] out_char,
  output logic             out_flag,
  output logic             out_run_last,
  output logic             out_text_end,
  output logic [1:0]       out_detected
);

  logic             load;
  logic             second;   // LF half of a CR LF still to send
  nlnorm_pkg::cmd_t held;

  // an item leaves the queue on its first beat, the held copy serves the second
  assign load = !out_valid || out_ready;
  assign pop  = load && !second && !empty;

  // output register and second beat tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      second    <= 1'b0;
    end else if (load) begin
      if (second) begin
        out_valid <= 1'b1;
        second    <= 1'b0;
      end else if (!empty) begin
        out_valid <= 1'b1;
        second    <= head.dual;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (load) begin
      if (second) begin
        out_char     <= nlnorm_pkg::CH_LF;
        out_flag     <= 1'b1;
        out_run_last <= 1'b1;
        out_text_end <= held.last;
        out_detected <= held.detected;
      end else begin
        held         <= head;
        out_char     <= head.ch;
        out_flag     <= head.valid;
        out_run_last <= !head.dual;
        out_text_end <= head.last && !head.dual;
        out_detected <= head.dual ? nlnorm_pkg::STYLE_LF : head.detected;
      end
    end
  end

endmodule
`default_nettype wire

// ===== design/newline_normalizer_top.sv =====
// Newline normalizer top level: front end, item queue and emit side.
// Inputs pass through the item queue, then the output register.
// Throughput: one input per cycle while the queue is not full. The single
// output register sends one character per cycle while the receiver takes
// it, a CR LF newline as CR and then LF. Reset (synchronous): counters,
// pending terminator, queue and output valid clear; style returns to CR LF.
`timescale 1ns / 1ps
`default_nettype none
module newline_normalizer_top (
  input  wire  logic        clk,
  input  wire  logic        rst,
  input  wire  logic        cfg_we,
  input  wire  logic [1:0]  cfg_wdata,
  input  wire  logic        s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire  logic [15:0] s_axis_tdata,   // char_code[15:0]
  input  wire  logic        s_axis_tlast,   // text_last
  output logic              m_axis_tvalid,
  input  wire  logic        m_axis_tready,
  output logic [23:0]       m_axis_tdata,   // out_char[15:0], run_last[16],
                                            // detected_style[18:17], zero[23:19]
  output logic              m_axis_tuser,   // out_valid
  output logic              m_axis_tlast    // text_end
);

  logic                  push, pop, full, empty;
  nlnorm_pkg::cmd_t      push_cmd, head;
  logic                  d_ready, d_valid;
  logic [15:0]           o_char;
  logic                  o_flag, o_run_last, o_text_end;
  logic [1:0]            o_detected;

  // front end
  nlnorm_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (s_axis_tvalid),
    .in_char    (s_axis_tdata),
    .in_last    (s_axis_tlast),
    .queue_full (full),
    .in_ready   (d_ready),
    .push       (push),
    .push_cmd   (push_cmd)
  );

  // item queue
  nlnorm_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .full     (full),
    .empty    (empty),
    .head     (head)
  );

  // emit side
  nlnorm_back u_back (
    .clk          (clk),
    .rst          (rst),
    .empty        (empty),
    .head         (head),
    .pop          (pop),
    .out_valid    (d_valid),
    .out_ready    (m_axis_tready),
    .out_char     (o_char),
    .out_flag     (o_flag),
    .out_run_last (o_run_last),
    .out_text_end (o_text_end),
    .out_detected (o_detected)
  );

  assign s_axis_tready = d_ready;
  assign m_axis_tvalid = d_valid;
  assign m_axis_tdata  = {5'b0, o_detected, o_run_last, o_char};
  assign m_axis_tuser  = o_flag;
  assign m_axis_tlast  = o_text_end;

`ifndef SYNTHESIS
  // end of text always closes the run of its input
  a_end_closes_run: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[16])
    else $error("text end without run end");

  // detected style only shown at the end of a text
  a_style_only_at_end: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tlast |-> m_axis_tdata[18:17] == nlnorm_pkg::STYLE_LF)
    else $error("detected style outside text end");

  // an open run is always the CR half of a CR LF newline
  a_open_run_is_cr: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tdata[16] |-> m_axis_tdata[15:0] == nlnorm_pkg::CH_CR)
    else $error("unexpected open run");

  // the queue is never written while full
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !full)
    else $error("queue overflow");
`endif

endmodule
`default_nettype wire

// ===== tb/sv/newline_normalizer_top_test.sv =====
// testbench of the newline normalizer top level with its own result predictor
`timescale 1ns / 1ps
module newline_normalizer_top_test;
  import nlnorm_pkg::*;

  // style code outside the named ones, behaves as cr lf
  localparam logic [1:0] STYLE_SPARE = 2'd3;
  localparam int STALL_LIMIT = 4000;
  localparam int MAX_REPORTS = 10;
  localparam int HOLDOFF_CYCLES = 150;

  // one result transfer, field by field
  typedef struct packed {
    logic [CHAR_WIDTH-1:0] ch;
    logic                  valid;
    logic                  run_last;
    logic                  text_end;
    logic [1:0]            style;
  } nl_result_t;

  // newline patterns used to build random texts
  typedef enum logic [1:0] {
    PAT_LF,
    PAT_CR,
    PAT_CRLF,
    PAT_LFCR
  } nl_pattern_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_wdata = 2'd0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = 16'd0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        m_axis_tlast;

  // predictor state
  logic [1:0]             nl_style = STYLE_CRLF;
  pend_t                  trail = PEND_NONE;
  logic [COUNT_WIDTH-1:0] seen_cr = '0;
  logic [COUNT_WIDTH-1:0] seen_lf = '0;
  logic [COUNT_WIDTH-1:0] seen_crlf = '0;
  nl_result_t             expected_chars[$];
  logic [15:0]            text_buf[$];

  int mismatches = 0;
  int stall_cycles = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_left = 0;

  newline_normalizer_top DUT (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic nl_result_t char_result(input logic [CHAR_WIDTH-1:0] c);
    nl_result_t r;
    r = '0;
    r.ch = c;
    r.valid = 1'b1;
    return r;
  endfunction

  function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  // majority style: lf wins ties with cr, cr must beat both, else cr lf
  function automatic logic [1:0] majority_style();
    if (seen_lf > seen_crlf && seen_lf >= seen_cr) return STYLE_LF;
    if (seen_cr > seen_lf && seen_cr > seen_crlf) return STYLE_CR;
    return STYLE_CRLF;
  endfunction

  // expected results of one accepted character
  task automatic predict_char(input logic [15:0] c, input logic l);
    nl_result_t burst [2];
    int         n;
    logic       fresh;
    n = 0;
    fresh = 1'b1;
    // settle the terminator emitted before this character
    case (trail)
      PEND_CR: begin
        if (c == CH_LF) begin
          trail = PEND_CRLF;
          fresh = 1'b0;
        end else begin
          seen_cr = sat_inc(seen_cr);
          trail = PEND_NONE;
        end
      end
      PEND_LF: begin
        trail = PEND_NONE;
        if (c == CH_CR) fresh = 1'b0;
        else seen_lf = sat_inc(seen_lf);
      end
      PEND_CRLF: begin
        seen_crlf = sat_inc(seen_crlf);
        trail = PEND_NONE;
      end
      default: ;
    endcase
    // rewrite newlines, pass everything else
    if (fresh) begin
      if (c == CH_CR || c == CH_LF) begin
        if (nl_style == STYLE_LF) begin
          burst[0] = char_result(CH_LF);
          n = 1;
        end else if (nl_style == STYLE_CR) begin
          burst[0] = char_result(CH_CR);
          n = 1;
        end else begin
          burst[0] = char_result(CH_CR);
          burst[1] = char_result(CH_LF);
          n = 2;
        end
        trail = (c == CH_CR) ? PEND_CR : PEND_LF;
      end else begin
        burst[0] = char_result(c);
        n = 1;
      end
    end
    // end of text: empty marker if swallowed, report style, clear state
    if (l) begin
      if (n == 0) begin
        burst[0] = '0;
        n = 1;
      end
      burst[n-1].text_end = 1'b1;
      burst[n-1].style = majority_style();
      trail = PEND_NONE;
      seen_cr = '0;
      seen_lf = '0;
      seen_crlf = '0;
    end
    if (n > 0) burst[n-1].run_last = 1'b1;
    for (int i = 0; i < n; i++) expected_chars.push_back(burst[i]);
  endtask

  // offer one character, with random idle cycles before it
  task automatic send_char(input logic [15:0] c, input logic l);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= c;
    s_axis_tlast <= l;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    predict_char(c, l);
  endtask

  // stop offering and let every expected result come out
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (expected_chars.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_style(input logic [1:0] v);
    wait_drained();
    cfg_wdata <= v;
    cfg_we <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
    nl_style = v;
  endtask

  // one random text, mostly newlines in one style and plain characters
  task automatic send_random_text(output int sent);
    int          len;
    int          r;
    nl_pattern_t bias;
    nl_pattern_t kind;
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 120) : $urandom_range(1, 16);
    bias = nl_pattern_t'($urandom_range(0, 2));
    text_buf.delete();
    while (text_buf.size() < len) begin
      r = $urandom_range(0, 99);
      if (r < 36) begin
        kind = (r < 26) ? bias : nl_pattern_t'($urandom_range(0, 3));
        case (kind)
          PAT_LF: text_buf.push_back(CH_LF);
          PAT_CR: text_buf.push_back(CH_CR);
          PAT_CRLF: begin
            text_buf.push_back(CH_CR);
            text_buf.push_back(CH_LF);
          end
          default: begin
            text_buf.push_back(CH_LF);
            text_buf.push_back(CH_CR);
          end
        endcase
      end else if (r < 41) begin
        // newline code in the low byte only
        text_buf.push_back({8'($urandom_range(1, 255)), (r[0] ? 8'h0D : 8'h0A)});
      end else if (r < 46) begin
        text_buf.push_back(16'($urandom_range(9, 14)));
      end else begin
        text_buf.push_back(16'($urandom));
      end
    end
    for (int i = 0; i < text_buf.size(); i++) send_char(text_buf[i], i == text_buf.size() - 1);
    sent = text_buf.size();
  endtask

  // default style after reset, plain extremes and a counted cr lf
  task automatic test_reset_defaults();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    send_char(16'h0041, 1'b0);
    send_char(CH_CR, 1'b0);
    send_char(CH_LF, 1'b0);
    send_char(16'hFFFF, 1'b0);
    send_char(16'h0000, 1'b1);
  endtask

  // each style, swallowed characters at the end, majority decisions
  task automatic test_directed_cases();
    // lf then cr merged, cr majority, lf ending the text
    write_style(STYLE_LF);
    send_char(CH_LF, 1'b0);
    send_char(CH_CR, 1'b0);
    send_char(CH_CR, 1'b0);
    send_char(16'h0030, 1'b0);
    send_char(CH_LF, 1'b1);
    // swallowed lf of a cr lf as the last character
    write_style(STYLE_CR);
    send_char(CH_CR, 1'b0);
    send_char(CH_LF, 1'b1);
    // swallowed cr of an lf cr as the last character
    write_style(STYLE_SPARE);
    send_char(CH_LF, 1'b0);
    send_char(CH_CR, 1'b1);
    // two separate lf, lf majority
    write_style(STYLE_CR);
    send_char(CH_LF, 1'b0);
    send_char(CH_LF, 1'b0);
    send_char(16'h000B, 1'b0);
    send_char(CH_CR, 1'b1);
    // near miss ending in a cr, then a one-character text
    write_style(STYLE_CRLF);
    send_char(16'h0D0A, 1'b0);
    send_char(CH_CR, 1'b1);
    send_char(16'h0000, 1'b1);
  endtask

  task automatic test_random_phase(input logic [1:0] style, input int snd_pct,
                                   input int rcv_pct, input int count);
    int sent;
    int total;
    total = 0;
    write_style(style);
    send_idle_pct = snd_pct;
    recv_stall_pct = rcv_pct;
    while (total < count) begin
      send_random_text(sent);
      total += sent;
    end
  endtask

  // receiver holds off long enough for the input to stall
  task automatic test_output_holdoff();
    int sent;
    int total;
    total = 0;
    write_style(STYLE_CRLF);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_left = HOLDOFF_CYCLES;
    while (total < 40) begin
      send_random_text(sent);
      total += sent;
    end
    wait_drained();
  endtask

  // sender waits for every result after each text
  task automatic test_sender_pause();
    int sent;
    int total;
    total = 0;
    write_style(STYLE_CR);
    send_idle_pct = 7;
    recv_stall_pct = 7;
    while (total < 150) begin
      send_random_text(sent);
      total += sent;
      wait_drained();
    end
  endtask

  // receiver readiness, with an optional long hold-off
  initial begin
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        m_axis_tready <= 1'b0;
        hold_left = hold_left - 1;
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  task automatic report_mismatch(input string what, input nl_result_t want,
                                 input nl_result_t got);
    if (mismatches < MAX_REPORTS)
      $display("mismatch (%s): expected char %h valid %b run_last %b text_end %b style %0d,",
               what, want.ch, want.valid, want.run_last, want.text_end, want.style,
               " got char %h valid %b run_last %b text_end %b style %0d raw %h",
               got.ch, got.valid, got.run_last, got.text_end, got.style, m_axis_tdata);
    mismatches++;
  endtask

  // compare each result transfer with the oldest expectation
  always @(posedge clk) begin : check_output
    nl_result_t got;
    nl_result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.ch = m_axis_tdata[15:0];
      got.run_last = m_axis_tdata[16];
      got.style = m_axis_tdata[18:17];
      got.valid = m_axis_tuser;
      got.text_end = m_axis_tlast;
      if (expected_chars.size() == 0) begin
        report_mismatch("nothing expected", '0, got);
      end else begin
        want = expected_chars.pop_front();
        if (got != want || m_axis_tdata[23:19] != 5'd0) report_mismatch("fields", want, got);
      end
    end
  end

  // watchdog on cycles without any transfer
  initial begin
    while (stall_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        stall_cycles = 0;
      else
        stall_cycles++;
    end
    $display("[newline_normalizer_top] ERROR");
    $finish;
  end

  // test sequence
  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_directed_cases();
    test_random_phase(STYLE_LF, 0, 0, 300);
    test_random_phase(STYLE_CR, 86, 0, 250);
    test_random_phase(STYLE_CRLF, 0, 86, 250);
    test_random_phase(STYLE_SPARE, 7, 7, 300);
    test_output_holdoff();
    test_sender_pause();
    test_random_phase(STYLE_LF, 30, 30, 220);
    wait_drained();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && expected_chars.size() == 0)
      $display("[newline_normalizer_top] OK");
    else
      $display("[newline_normalizer_top] ERROR");
    $finish;
  end

endmodule
